// ----- design/vn_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vn_pkg
// Shared types and constants of the vector normalizer pipeline.
// ----------------------------------------------------------------------------
package vn_pkg;

	localparam int CompW   = 24;
	localparam int SumW    = 48;
	localparam int ResW    = 50;
	localparam int LenW    = 24;
	localparam int QuotW   = 23;
	localparam int RemW    = 25;
	localparam int MinLenW = 23;
	localparam int SqrtSteps = 24;
	localparam int DivSteps  = 23;

	typedef struct packed {
		logic                        valid;
		logic [SumW-1:0]             rem;
		logic [ResW-1:0]             res;
		logic [2:0][CompW-1:0]       mag;
		logic [2:0]                  neg;
	} sq_t;

	typedef struct packed {
		logic                        valid;
		logic                        degen;
		logic [LenW-1:0]             len;
		logic [2:0][RemW-1:0]        rem;
		logic [2:0][QuotW-1:0]       quot;
		logic [2:0]                  neg;
	} dv_t;

endpackage

// ----- design/vn_sqrt_stage.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vn_sqrt_stage
// One registered step of the bitwise integer square root.
// ----------------------------------------------------------------------------
module vn_sqrt_stage import vn_pkg::*; #(
	parameter int Step = 0
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  sq_t  din,
	output sq_t  dout
);

	localparam logic [ResW-1:0] Bit = ResW'(1) << (46 - 2 * Step);

	logic [ResW-1:0] trial;
	sq_t             nxt;
	sq_t             pipe_s1;

	always_comb begin
		nxt   = din;
		trial = din.res + Bit;
		if ({{(ResW-SumW){1'b0}}, din.rem} >= trial) begin
			nxt.rem = din.rem - trial[SumW-1:0];
			nxt.res = (din.res >> 1) + Bit;
		end else begin
			nxt.res = din.res >> 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pipe_s1 <= '0;
		end else if (en) begin
			pipe_s1 <= nxt;
		end
	end

	assign dout = pipe_s1;

endmodule

// ----- design/vn_div_stage.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vn_div_stage
// One registered restoring-division step for all three components.
// ----------------------------------------------------------------------------
module vn_div_stage import vn_pkg::*; #(
	parameter int Step = 0
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  dv_t  din,
	output dv_t  dout
);

	logic [RemW-1:0] r [3];
	dv_t             nxt;
	dv_t             pipe_s1;

	always_comb begin
		nxt = din;
		for (int i = 0; i < 3; i++) begin
			r[i] = (Step == 0) ? din.rem[i] : {din.rem[i][RemW-2:0], 1'b0};
			if (r[i] >= {1'b0, din.len}) begin
				nxt.rem[i]  = r[i] - {1'b0, din.len};
				nxt.quot[i] = {din.quot[i][QuotW-2:0], 1'b1};
			end else begin
				nxt.rem[i]  = r[i];
				nxt.quot[i] = {din.quot[i][QuotW-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pipe_s1 <= '0;
		end else if (en) begin
			pipe_s1 <= nxt;
		end
	end

	assign dout = pipe_s1;

endmodule

// ----- design/vector3_normalizer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector3_normalizer
// Scales a Q8.16 3D vector to a Q1.22 unit vector, flagging short vectors.
// ----------------------------------------------------------------------------
// Channel  Direction  Contents
// s_*      in         vec_x, vec_y, vec_z
// m_*      out        unit_x, unit_y, unit_z; tuser = degenerate
// cfg_*    in         min_length
// One transaction is accepted per cycle while the output is not held. The
// pipeline holds the magnitude and square stages, the 24 square-root steps,
// the 23 division steps and the output register, one register stage each.
// Reset clears all valid bits and sets min_length to 1.
// When the output is held, the whole pipeline stalls and nothing is lost.
// ----------------------------------------------------------------------------
module vector3_normalizer import vn_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,   // vec_x, vec_y, vec_z
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,   // unit_x, unit_y, unit_z
	output logic        m_tuser,   // degenerate
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [22:0] cfg_data
);

	logic                 en;
	logic [MinLenW-1:0]   min_length_q;
	logic                 v_s1, v_s2;
	logic [2:0][CompW-1:0] mag_s1, mag_s2;
	logic [2:0]           neg_s1, neg_s2;
	logic [2:0][SumW-1:0] sqr_s2;
	sq_t                  sq [SqrtSteps+1];
	dv_t                  dv [DivSteps+1];
	logic                 out_v_q;
	logic [71:0]          out_data_q;
	logic                 out_degen_q;
	logic [CompW-1:0]     comp [3];

	assign en        = !out_v_q || m_tready;
	assign s_tready  = en;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_length_q <= MinLenW'(1);
		end else if (cfg_valid) begin
			min_length_q <= cfg_data;
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			comp[i] = s_tdata[i*CompW +: CompW];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				neg_s1[i] <= comp[i][CompW-1];
				mag_s1[i] <= comp[i][CompW-1] ? (~comp[i] + CompW'(1)) : comp[i];
				sqr_s2[i] <= mag_s1[i] * mag_s1[i];
			end
			neg_s2 <= neg_s1;
			mag_s2 <= mag_s1;
		end
	end

	always_comb begin
		sq[0].valid = v_s2;
		sq[0].rem   = sqr_s2[0] + sqr_s2[1] + sqr_s2[2];
		sq[0].res   = '0;
		sq[0].mag   = mag_s2;
		sq[0].neg   = neg_s2;
	end

	for (genvar g = 0; g < SqrtSteps; g++) begin : g_sqrt
		vn_sqrt_stage #(.Step(g)) u_stage (
			.clk(clk), .arst_n(arst_n), .en(en), .din(sq[g]), .dout(sq[g+1])
		);
	end

	always_comb begin
		dv[0].valid = sq[SqrtSteps].valid;
		dv[0].len   = sq[SqrtSteps].res[LenW-1:0];
		dv[0].degen = (sq[SqrtSteps].res[LenW-1:0] == '0) ||
			(sq[SqrtSteps].res[LenW-1:0] < {1'b0, min_length_q});
		dv[0].neg   = sq[SqrtSteps].neg;
		dv[0].quot  = '0;
		for (int i = 0; i < 3; i++) begin
			dv[0].rem[i] = {1'b0, sq[SqrtSteps].mag[i]};
		end
	end

	for (genvar g = 0; g < DivSteps; g++) begin : g_div
		vn_div_stage #(.Step(g)) u_stage (
			.clk(clk), .arst_n(arst_n), .en(en), .din(dv[g]), .dout(dv[g+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en) begin
			out_v_q <= dv[DivSteps].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_degen_q <= dv[DivSteps].degen;
			for (int i = 0; i < 3; i++) begin
				if (dv[DivSteps].degen) begin
					out_data_q[i*CompW +: CompW] <= '0;
				end else if (dv[DivSteps].neg[i]) begin
					out_data_q[i*CompW +: CompW] <= CompW'(0) -
						{1'b0, dv[DivSteps].quot[i]};
				end else begin
					out_data_q[i*CompW +: CompW] <= {1'b0, dv[DivSteps].quot[i]};
				end
			end
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_degen_q;

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == '0)
		else $error("degenerate result with nonzero vector");

	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("input ready does not follow output stall");

	a_quot_range: assert property (@(posedge clk) disable iff (!arst_n)
		dv[DivSteps].valid && !dv[DivSteps].degen |->
			dv[DivSteps].quot[0] <= QuotW'(4194304))
		else $error("quotient above one");

endmodule
